/* hdl/gtq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue package
// Sizes, command and status codes, and the types shared by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package gtq_pkg;

	// Pool and team sizes.
	localparam int CAPACITY   = 1024;
	localparam int TEAMS      = 1024;
	localparam int VALUE_BITS = 20;

	localparam int NODE_W = $clog2(CAPACITY);
	localparam int TEAM_W = $clog2(TEAMS);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Command codes.
	localparam logic [1:0] CMD_ENQ   = 2'd0;
	localparam logic [1:0] CMD_DEQ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One input item.
	typedef struct packed {
		logic [1:0]  command;
		logic [19:0] value;
		logic [9:0]  team;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [19:0] out_value;
		logic [1:0]  status;
	} result_t;

	// One entry of the team table: present mark and tail node.
	typedef struct packed {
		logic              present;
		logic [NODE_W-1:0] tail;
	} team_entry_t;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic       load_item;
		logic       enq_rd;
		logic       enq_alloc;
		logic       enq_link_new;
		logic       enq_link_prev;
		logic       deq_rd;
		logic       deq_unlink;
		logic       deq_team;
		logic       clr_init;
		logic       clr_step;
		logic       res_valid;
		logic       res_take_value;
		logic [1:0] res_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic sweep_last;
	} dp_sts_t;

endpackage

/* hdl/grouped_team_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue
// Team queue kept as a linked list in a node pool. Enqueued values join
// behind the last waiting member of their team, or at the queue tail.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload   Width
//  input     start / busy     item      32 (command, value, team)
//  output    done (strobe)    result    22 (out_value, status)
//
//  An item is accepted at a clock edge with start high and busy low; its
//  result shows on result with done high for one cycle, and the receiver
//  cannot stall it; rejected, clear and unknown items get theirs next cycle.
//  An enqueue runs read, allocate, link new and link previous steps, and a
//  dequeue read, unlink and team update steps, all with busy high; each
//  memory step waits on the registered read of the node pool or team table.
//  Reset and a clear sweep the 1024 team table entries one a cycle, busy high.
// ----------------------------------------------------------------------------
module grouped_team_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gtq_pkg::item_t   item,
	output logic             done,
	output gtq_pkg::result_t result
);
	import gtq_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Sequencer.
	gtq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (item.command),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	// Memories and queue registers.
	gtq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	// A pool with every node allocated cannot have an empty queue.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sts.full |-> !sts.empty)
		else $error("pool full while queue empty");

	// A dequeue on an empty queue answers with the empty status next cycle.
	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_DEQ) && sts.empty
		|=> done && (result.status == ST_EMPTY))
		else $error("dequeue on empty queue not flagged");

	// An accepted enqueue with room starts work on the memories.
	a_enq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_ENQ) && !sts.full |=> busy)
		else $error("enqueue did not start");

	// A result only follows an accepted item or work in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without an item");

endmodule

/* hdl/gtq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue controller
// State machine that sequences the memory steps of enqueue, dequeue and the
// team table clearing pass, and issues the result strobe.
// ----------------------------------------------------------------------------
module gtq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         command,
	input  gtq_pkg::dp_sts_t   sts,
	output logic               busy,
	output gtq_pkg::ctrl_cmd_t cmd
);
	import gtq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ENQ_A = 4'd1;
	localparam logic [3:0] S_ENQ_B = 4'd2;
	localparam logic [3:0] S_ENQ_C = 4'd3;
	localparam logic [3:0] S_ENQ_D = 4'd4;
	localparam logic [3:0] S_DEQ_A = 4'd5;
	localparam logic [3:0] S_DEQ_B = 4'd6;
	localparam logic [3:0] S_DEQ_C = 4'd7;
	localparam logic [3:0] S_CLEAR = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Next state and step commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command)
						CMD_ENQ: begin
							if (sts.full) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ST_FULL;
							end else begin
								cmd.load_item = 1'b1;
								state_d       = S_ENQ_A;
							end
						end
						CMD_DEQ: begin
							if (sts.empty) begin
								cmd.res_valid  = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else begin
								state_d = S_DEQ_A;
							end
						end
						CMD_CLEAR: begin
							cmd.clr_init   = 1'b1;
							cmd.res_valid  = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_CLEAR;
						end
						default: begin
							cmd.res_valid  = 1'b1;
							cmd.res_status = ST_OK;
						end
					endcase
				end
			end
			S_ENQ_A: begin
				cmd.enq_rd = 1'b1;
				state_d    = S_ENQ_B;
			end
			S_ENQ_B: begin
				cmd.enq_alloc = 1'b1;
				state_d       = S_ENQ_C;
			end
			S_ENQ_C: begin
				cmd.enq_link_new = 1'b1;
				state_d          = S_ENQ_D;
			end
			S_ENQ_D: begin
				cmd.enq_link_prev = 1'b1;
				cmd.res_valid     = 1'b1;
				cmd.res_status    = ST_OK;
				state_d           = S_IDLE;
			end
			S_DEQ_A: begin
				cmd.deq_rd = 1'b1;
				state_d    = S_DEQ_B;
			end
			S_DEQ_B: begin
				cmd.deq_unlink = 1'b1;
				state_d        = S_DEQ_C;
			end
			S_DEQ_C: begin
				cmd.deq_team       = 1'b1;
				cmd.res_valid      = 1'b1;
				cmd.res_take_value = 1'b1;
				cmd.res_status     = ST_OK;
				state_d            = S_IDLE;
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the team table clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* hdl/gtq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue datapath
// Node pool memories, team table, queue and free list registers, and the
// result register, all driven by step commands from the controller.
// ----------------------------------------------------------------------------
module gtq_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  gtq_pkg::item_t     item,
	input  gtq_pkg::ctrl_cmd_t cmd,
	output gtq_pkg::dp_sts_t   sts,
	output logic               done,
	output gtq_pkg::result_t   result
);
	import gtq_pkg::*;

	// Node pool and team table.
	logic [VALUE_BITS-1:0] value_mem [CAPACITY];
	logic [TEAM_W-1:0]     nteam_mem [CAPACITY];
	logic [NODE_W-1:0]     link_mem  [CAPACITY];
	team_entry_t           team_mem  [TEAMS];

	// Registered read data.
	logic [VALUE_BITS-1:0] value_rd_q;
	logic [TEAM_W-1:0]     nteam_rd_q;
	logic [NODE_W-1:0]     link_rd_q;
	team_entry_t           team_rd_q;

	// Item and work registers.
	logic [VALUE_BITS-1:0] val_q;
	logic [TEAM_W-1:0]     team_q;
	logic [NODE_W-1:0]     node_q;
	logic [NODE_W-1:0]     prev_q;
	logic                  present_q;

	// Queue and free list registers.
	logic [NODE_W-1:0] head_q;
	logic [NODE_W-1:0] tail_q;
	logic [CNT_W-1:0]  occ_q;
	logic [NODE_W-1:0] fhead_q;
	logic [CNT_W-1:0]  fcount_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [TEAM_W-1:0] sweep_q;

	// Memory port controls.
	logic              link_we;
	logic [NODE_W-1:0] link_wa;
	logic [NODE_W-1:0] link_wd;
	logic              link_re;
	logic [NODE_W-1:0] link_ra;
	logic              team_we;
	logic [TEAM_W-1:0] team_wa;
	team_entry_t       team_wd;
	logic              team_re;
	logic [TEAM_W-1:0] team_ra;
	logic [NODE_W-1:0] alloc_node;

	// A node comes from the free list first, then from the untouched part.
	assign alloc_node = (fcount_q != '0) ? fhead_q : fresh_q[NODE_W-1:0];

	// Link memory port selection.
	always_comb begin
		link_we = 1'b0;
		link_wa = node_q;
		link_wd = '0;
		if (cmd.enq_link_new) begin
			link_we = 1'b1;
			link_wa = node_q;
			link_wd = present_q ? link_rd_q : '0;
		end else if (cmd.enq_link_prev) begin
			link_we = present_q || (occ_q != '0);
			link_wa = present_q ? prev_q : tail_q;
			link_wd = node_q;
		end else if (cmd.deq_unlink) begin
			link_we = 1'b1;
			link_wa = head_q;
			link_wd = fhead_q;
		end
		link_re = cmd.enq_rd || cmd.enq_alloc || cmd.deq_rd;
		if (cmd.enq_rd) begin
			link_ra = fhead_q;
		end else if (cmd.enq_alloc) begin
			link_ra = team_rd_q.tail;
		end else begin
			link_ra = head_q;
		end
	end

	// Team table port selection.
	always_comb begin
		team_we = 1'b0;
		team_wa = team_q;
		team_wd = '0;
		if (cmd.enq_alloc) begin
			team_we         = 1'b1;
			team_wa         = team_q;
			team_wd.present = 1'b1;
			team_wd.tail    = alloc_node;
		end else if (cmd.deq_team) begin
			team_we         = team_rd_q.present && (team_rd_q.tail == node_q);
			team_wa         = nteam_rd_q;
			team_wd.present = 1'b0;
			team_wd.tail    = team_rd_q.tail;
		end else if (cmd.clr_step) begin
			team_we = 1'b1;
			team_wa = sweep_q;
			team_wd = '0;
		end
		team_re = cmd.enq_rd || cmd.deq_unlink;
		team_ra = cmd.enq_rd ? team_q : nteam_rd_q;
	end

	// Link memory.
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra];
		end
	end

	// Team table memory.
	always_ff @(posedge clk) begin
		if (team_we) begin
			team_mem[team_wa] <= team_wd;
		end
		if (team_re) begin
			team_rd_q <= team_mem[team_ra];
		end
	end

	// Node value and node team memories.
	always_ff @(posedge clk) begin
		if (cmd.enq_alloc) begin
			value_mem[alloc_node] <= val_q;
			nteam_mem[alloc_node] <= team_q;
		end
		if (cmd.deq_rd) begin
			value_rd_q <= value_mem[head_q];
			nteam_rd_q <= nteam_mem[head_q];
		end
	end

	// Item and work registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			val_q  <= item.value[VALUE_BITS-1:0];
			team_q <= item.team[TEAM_W-1:0];
		end
		if (cmd.enq_alloc) begin
			node_q    <= alloc_node;
			prev_q    <= team_rd_q.tail;
			present_q <= team_rd_q.present;
		end else if (cmd.deq_unlink) begin
			node_q <= head_q;
		end
	end

	// Queue, free list and sweep registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			fhead_q  <= '0;
			fcount_q <= '0;
			fresh_q  <= '0;
			sweep_q  <= '0;
		end else if (cmd.clr_init) begin
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			fhead_q  <= '0;
			fcount_q <= '0;
			fresh_q  <= '0;
			sweep_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			// Take the node off the free list or the untouched part.
			if (cmd.enq_alloc) begin
				if (fcount_q != '0) begin
					fhead_q  <= link_rd_q;
					fcount_q <= fcount_q - 1'b1;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			// Splice the new node into the queue.
			if (cmd.enq_link_prev) begin
				if (present_q) begin
					if (tail_q == prev_q) begin
						tail_q <= node_q;
					end
				end else begin
					if (occ_q == '0) begin
						head_q <= node_q;
					end
					tail_q <= node_q;
				end
				occ_q <= occ_q + 1'b1;
			end
			// Pop the head node and push it onto the free list.
			if (cmd.deq_unlink) begin
				head_q   <= link_rd_q;
				occ_q    <= occ_q - 1'b1;
				fhead_q  <= head_q;
				fcount_q <= fcount_q + 1'b1;
			end
		end
	end

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_valid) begin
			result.out_value <= cmd.res_take_value ? value_rd_q : '0;
			result.status    <= cmd.res_status;
		end
	end

	// Status toward the controller.
	assign sts.full       = (fcount_q == '0) && (fresh_q == CNT_W'(CAPACITY));
	assign sts.empty      = (occ_q == '0);
	assign sts.sweep_last = (sweep_q == TEAM_W'(TEAMS - 1));

endmodule

/* test/gtq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue checker
// Watches the command and result channels of the team queue. Every accepted
// item is run through a behavioral copy of the queue. The result it should
// give is then queued and compared field by field with the next result
// strobe. The number of failures and of results still awaited are passed up.
// ----------------------------------------------------------------------------
module gtq_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  gtq_pkg::item_t   item,
	input  logic             done,
	input  gtq_pkg::result_t result,
	output int               mismatch_count,
	output int               pending_results
);
	import gtq_pkg::*;

	// Behavioral copy of the node pool, the team table and the list pointers.
	logic [VALUE_BITS-1:0] pool_value [CAPACITY];
	logic [NODE_W-1:0]     pool_link  [CAPACITY];
	logic [TEAM_W-1:0]     pool_team  [CAPACITY];
	logic [NODE_W-1:0]     team_last  [TEAMS];
	bit                    team_waiting [TEAMS];
	logic [NODE_W-1:0]     head_node;
	logic [NODE_W-1:0]     tail_node;
	logic [NODE_W-1:0]     free_top;
	int                    queued_count;
	int                    free_count;
	int                    fresh_count;

	result_t expected_results [$];
	int      failures;

	// Empty every queue and the pool; node contents are left as they are.
	function automatic void clear_pool();
		for (int i = 0; i < TEAMS; i++)
			team_waiting[i] = 1'b0;
		head_node    = '0;
		tail_node    = '0;
		free_top     = '0;
		queued_count = 0;
		free_count   = 0;
		fresh_count  = 0;
	endfunction

	// Take a node from the free list first, then from the never used ones.
	function automatic bit grab_node(output logic [NODE_W-1:0] node);
		if (free_count > 0) begin
			node     = free_top;
			free_top = pool_link[node];
			free_count--;
			return 1'b1;
		end
		if (fresh_count < CAPACITY) begin
			node = NODE_W'(fresh_count);
			fresh_count++;
			return 1'b1;
		end
		node = '0;
		return 1'b0;
	endfunction

	// Apply one item to the queue copy and return the result it should give.
	function automatic result_t team_queue_step(input item_t it);
		result_t           res;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] prev;
		logic [TEAM_W-1:0] tm;
		res           = '0;
		res.status    = ST_OK;
		case (it.command)
		CMD_ENQ: begin
			tm = it.team;
			if (!grab_node(node)) begin
				res.status = ST_FULL;
			end else begin
				pool_value[node] = it.value;
				pool_team[node]  = tm;
				if (team_waiting[tm]) begin
					// Join directly behind the last waiting team member.
					prev            = team_last[tm];
					pool_link[node] = pool_link[prev];
					pool_link[prev] = node;
					if (tail_node == prev)
						tail_node = node;
				end else begin
					// First of its team: go to the tail of the whole queue.
					pool_link[node] = '0;
					if (queued_count == 0)
						head_node = node;
					else
						pool_link[tail_node] = node;
					tail_node        = node;
					team_waiting[tm] = 1'b1;
				end
				team_last[tm] = node;
				queued_count++;
			end
		end
		CMD_DEQ: begin
			if (queued_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				node          = head_node;
				res.out_value = pool_value[node];
				tm            = pool_team[node];
				if (team_waiting[tm] && team_last[tm] == node)
					team_waiting[tm] = 1'b0;
				head_node = pool_link[node];
				queued_count--;
				// The freed node goes on top of the free list.
				pool_link[node] = free_top;
				free_top        = node;
				free_count++;
			end
		end
		CMD_CLEAR: begin
			clear_pool();
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	// Compare the result of this edge first, then predict the item taken now.
	always @(posedge clk or negedge arst_n) begin
		result_t oldest;
		if (!arst_n) begin
			clear_pool();
			expected_results.delete();
			failures = 0;
			mismatch_count  <= 0;
			pending_results <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result value %h status %0d",
							$time, result.out_value, result.status);
				end else begin
					oldest = expected_results.pop_front();
					if (result.out_value !== oldest.out_value ||
						result.status !== oldest.status) begin
						failures++;
						if (failures <= 10)
							$display("%0t: mismatch: expected %h / %0d, got %h / %0d",
								$time, oldest.out_value, oldest.status,
								result.out_value, result.status);
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(team_queue_step(item));
			mismatch_count  <= failures;
			pending_results <= expected_results.size();
		end
	end

endmodule

/* test/tb_grouped_team_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped team queue testbench
// Drives the team queue with a directed opening, random traffic in teams
// drawn from small sets, and a run that fills the node pool to overflow.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grouped_team_queue;
	import gtq_pkg::*;

	// The command code that the block ignores.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	int      mismatches;
	int      outstanding;

	logic [TEAM_W-1:0] team_choices [8];

	grouped_team_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	gtq_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.done            (done),
		.result          (result),
		.mismatch_count  (mismatches),
		.pending_results (outstanding)
	);

	always #6 clk = ~clk;

	// Watchdog for a hung block.
	initial begin
		#100ms;
		$display("tb_grouped_team_queue: errors");
		$finish;
	end

	function automatic item_t make_item(input logic [1:0] cmd, input logic [19:0] val,
		input logic [9:0] tm);
		item_t it;
		it.command = cmd;
		it.value   = val;
		it.team    = tm;
		return it;
	endfunction

	// Pick a fresh set of teams, the extremes among them now and then.
	task automatic refresh_teams();
		int pick;
		for (int i = 0; i < 8; i++) begin
			pick = $urandom_range(9);
			if (pick == 0)
				team_choices[i] = '0;
			else if (pick == 1)
				team_choices[i] = '1;
			else
				team_choices[i] = TEAM_W'($urandom_range(TEAMS - 1));
		end
	endtask

	// Mostly enqueues and dequeues on the current teams, some clears and noise.
	function automatic item_t random_item(input int enq_pct);
		int          pick;
		logic [1:0]  cmd;
		logic [19:0] val;
		logic [9:0]  tm;
		pick = $urandom_range(99);
		if (pick < 2)
			cmd = CMD_CLEAR;
		else if (pick < 4)
			cmd = CMD_UNKNOWN;
		else if (pick < 4 + enq_pct)
			cmd = CMD_ENQ;
		else
			cmd = CMD_DEQ;
		case ($urandom_range(9))
		0:       val = '0;
		1:       val = '1;
		default: val = 20'($urandom());
		endcase
		if ($urandom_range(4) == 0)
			tm = 10'($urandom());
		else
			tm = team_choices[$urandom_range(7)];
		return make_item(cmd, val, tm);
	endfunction

	// Hold start high until the block takes the item.
	task automatic push_item(input item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
	endtask

	// Sometimes leave an idle gap with start low after an item.
	task automatic idle_gap(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop sending until every awaited result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Random traffic in bursts, each with its own enqueue share and teams.
	task automatic run_phase(input int idle_pct, input int count);
		int enq_pct;
		enq_pct = 50;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(3))
				0:       enq_pct = 30;
				1:       enq_pct = 50;
				2:       enq_pct = 65;
				default: enq_pct = 85;
				endcase
				refresh_teams();
			end
			push_item(random_item(enq_pct));
			idle_gap(idle_pct);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty dequeue, ignored command, team joins and
		// team tail marks, free list reuse, and a clear.
		push_item(make_item(CMD_DEQ, 20'h0, 10'd0));
		push_item(make_item(CMD_UNKNOWN, 20'hFFFFF, 10'h3FF));
		push_item(make_item(CMD_ENQ, 20'hFFFFF, 10'd0));
		push_item(make_item(CMD_ENQ, 20'h00000, 10'h3FF));
		push_item(make_item(CMD_ENQ, 20'h12345, 10'd0));
		push_item(make_item(CMD_ENQ, 20'h5A5A5, 10'h3FF));
		push_item(make_item(CMD_ENQ, 20'hAAAAA, 10'd7));
		push_item(make_item(CMD_DEQ, 20'h0, 10'd0));
		push_item(make_item(CMD_DEQ, 20'h0, 10'd0));
		push_item(make_item(CMD_ENQ, 20'h55555, 10'd0));
		repeat (5) push_item(make_item(CMD_DEQ, 20'h0, 10'd0));
		push_item(make_item(CMD_ENQ, 20'h3C3C3, 10'd3));
		push_item(make_item(CMD_CLEAR, 20'hFFFFF, 10'h3FF));
		push_item(make_item(CMD_DEQ, 20'hFFFFF, 10'h3FF));
		push_item(make_item(CMD_ENQ, 20'h80000, 10'h200));
		push_item(make_item(CMD_DEQ, 20'h0, 10'd0));
		drain();

		// Random traffic: sender rarely idle, then often, then never.
		run_phase(26, 100);
		drain();
		run_phase(86, 80);
		run_phase(0, 80);
		drain();

		// Fill the pool past its size with a few dequeues mixed in, so freed
		// nodes and never used ones are both taken before it overflows.
		push_item(make_item(CMD_CLEAR, 20'h0, 10'd0));
		for (int k = 0; k < 1060; k++) begin
			if (k % 100 == 0)
				refresh_teams();
			if (k % 100 == 99)
				push_item(make_item(CMD_DEQ, 20'($urandom()), 10'($urandom())));
			else
				push_item(make_item(CMD_ENQ, 20'($urandom()),
					team_choices[$urandom_range(7)]));
		end
		for (int k = 0; k < 60; k++) begin
			push_item(random_item(50));
			idle_gap(26);
		end
		push_item(make_item(CMD_CLEAR, 20'h0, 10'd0));
		push_item(make_item(CMD_DEQ, 20'h0, 10'd0));

		// Wait for the last results, then a little longer for stray strobes.
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_grouped_team_queue: clean");
		end else begin
			$display("tb_grouped_team_queue: errors");
		end
		$finish;
	end

endmodule
